>>> design/dq_pkg.sv
// Package for the double-ended queue: word types, operation and error codes,
// sizing constants and ring index arithmetic. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // sizing
  localparam int DqDepth  = 16;
  localparam int DqDataW  = 32;
  localparam int DqIdxW   = $clog2(DqDepth);
  localparam int DqCountW = $clog2(DqDepth + 1);

  // operation codes
  typedef enum logic [2:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_CLEAR      = 3'd4
  } mode_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  // input word
  typedef struct packed {
    mode_e                      mode;
    logic signed [DqDataW-1:0]  value;
  } dq_in_t;

  // result word
  typedef struct packed {
    logic signed [DqDataW-1:0]  popped_value;
    err_e                       error;
    logic [DqCountW-1:0]        count;
    logic signed [DqDataW-1:0]  front_value;
    logic signed [DqDataW-1:0]  back_value;
  } dq_out_t;

  // ring index plus an offset below the depth, wrapped once
  function automatic logic [DqIdxW-1:0] idx_add(logic [DqIdxW-1:0]   base,
                                                logic [DqCountW-1:0] off);
    logic [DqCountW:0] sum;
    sum = {{(DqCountW + 1 - DqIdxW){1'b0}}, base} + {1'b0, off};
    if (sum >= (DqCountW + 1)'(DqDepth)) begin
      sum = sum - (DqCountW + 1)'(DqDepth);
    end
    return sum[DqIdxW-1:0];
  endfunction

  // ring index minus one
  function automatic logic [DqIdxW-1:0] idx_dec(logic [DqIdxW-1:0] base);
    logic [DqIdxW-1:0] res;
    if (base == '0) begin
      res = DqIdxW'(DqDepth - 1);
    end else begin
      res = base - DqIdxW'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> design/dq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_q
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/dq_core.sv
// Deque state and operation datapath: ring pointers, cached end words and the
// slot RAM. Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps
`default_nettype none

module dq_core import dq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire dq_in_t  op_i,
  output dq_out_t      res_o
);

  logic [DqIdxW-1:0]   front_q, front_d;
  logic [DqCountW-1:0] count_q, count_d;
  // cached words: two at the front, two at the back
  logic [DqDataW-1:0]  f0_q, f0_d, f1_q, f1_d, b0_q, b0_d, b1_q, b1_d;
  // second word at an end still arriving from the RAM
  logic                f1_pend_q, f1_pend_d, b1_pend_q, b1_pend_d;

  logic                we, re;
  logic [DqIdxW-1:0]   waddr, raddr;
  logic [DqDataW-1:0]  rdata;
  logic [DqDataW-1:0]  f1_eff, b1_eff, popped;
  logic                is_empty, is_one, is_full, ge_three;
  err_e                err;

  // slot storage
  dq_ram #(
    .WIDTH (DqDataW),
    .DEPTH (DqDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (op_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_q (rdata)
  );

  // resolve words still pending from the RAM
  assign f1_eff   = f1_pend_q ? rdata : f1_q;
  assign b1_eff   = b1_pend_q ? rdata : b1_q;
  assign is_empty = (count_q == '0);
  assign is_one   = (count_q == DqCountW'(1));
  assign is_full  = (count_q == DqCountW'(DqDepth));
  assign ge_three = (count_q >= DqCountW'(3));

  // operation decode and next state
  always_comb begin
    front_d   = front_q;
    count_d   = count_q;
    f0_d      = f0_q;
    f1_d      = f1_eff;
    b0_d      = b0_q;
    b1_d      = b1_eff;
    f1_pend_d = 1'b0;
    b1_pend_d = 1'b0;
    we        = 1'b0;
    waddr     = front_q;
    re        = 1'b0;
    raddr     = front_q;
    popped    = '0;
    err       = ERR_OK;
    unique case (op_i.mode)
      MODE_PUSH_BACK: begin
        if (is_full) begin
          err = ERR_FULL;
        end else begin
          we      = fire_i;
          waddr   = idx_add(front_q, count_q);
          count_d = count_q + DqCountW'(1);
          b0_d    = op_i.value;
          b1_d    = b0_q;
          if (is_empty) begin
            f0_d = op_i.value;
          end
          if (is_one) begin
            f1_d = op_i.value;
          end
        end
      end
      MODE_PUSH_FRONT: begin
        if (is_full) begin
          err = ERR_FULL;
        end else begin
          front_d = idx_dec(front_q);
          we      = fire_i;
          waddr   = idx_dec(front_q);
          count_d = count_q + DqCountW'(1);
          f0_d    = op_i.value;
          f1_d    = f0_q;
          if (is_empty) begin
            b0_d = op_i.value;
          end
          if (is_one) begin
            b1_d = op_i.value;
          end
        end
      end
      MODE_POP_BACK: begin
        if (is_empty) begin
          err = ERR_EMPTY;
        end else begin
          popped  = b0_q;
          count_d = count_q - DqCountW'(1);
          b0_d    = b1_eff;
          // fetch the word that becomes second from the back
          if (ge_three) begin
            re        = fire_i;
            raddr     = idx_add(front_q, count_q - DqCountW'(3));
            b1_pend_d = 1'b1;
          end
        end
      end
      MODE_POP_FRONT: begin
        if (is_empty) begin
          err = ERR_EMPTY;
        end else begin
          popped  = f0_q;
          front_d = idx_add(front_q, DqCountW'(1));
          count_d = count_q - DqCountW'(1);
          f0_d    = f1_eff;
          // fetch the word that becomes second from the front
          if (ge_three) begin
            re        = fire_i;
            raddr     = idx_add(front_q, DqCountW'(2));
            f1_pend_d = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // result word
  always_comb begin
    res_o.popped_value = popped;
    res_o.error        = err;
    res_o.count        = count_d;
    res_o.front_value  = (count_d == '0) ? '0 : f0_d;
    res_o.back_value   = (count_d == '0) ? '0 : b0_d;
  end

  // pointers and pending flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      f1_pend_q <= 1'b0;
      b1_pend_q <= 1'b0;
    end else if (fire_i) begin
      front_q   <= front_d;
      count_q   <= count_d;
      f1_pend_q <= f1_pend_d;
      b1_pend_q <= b1_pend_d;
    end
  end

  // cached end words
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      f0_q <= f0_d;
      f1_q <= f1_d;
      b0_q <= b0_d;
      b1_q <= b1_d;
    end
  end

`ifndef SYNTHESIS
  a_one_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f1_pend_q && b1_pend_q))
    else $error("both end caches wait on the RAM");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DqCountW'(DqDepth))
    else $error("count above depth");

  a_pend_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f1_pend_q || b1_pend_q) |-> (count_q >= DqCountW'(2)))
    else $error("pending fetch with fewer than two words held");

  a_empty_pop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_empty &&
     (op_i.mode == MODE_POP_BACK || op_i.mode == MODE_POP_FRONT))
    |=> ($stable(count_q) && $stable(front_q)))
    else $error("pop on empty changed the state");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_full &&
     (op_i.mode == MODE_PUSH_BACK || op_i.mode == MODE_PUSH_FRONT))
    |-> (!we && err == ERR_FULL))
    else $error("push on full reached the RAM");
`endif

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// Top level of the double-ended queue: input register, result register and
// valid/stall flow control. Depends on dq_pkg and dq_core.
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid_i/in_stall_o   | dq_in_t  in_data_i
//   out     | output    | out_valid_o/out_stall_i | dq_out_t out_data_o
//
// One word per cycle sustained while out_stall_i is low; a result reaches the outputs
// through the input register, which loads at the accepting edge, and then the
// result register.
// Each operation touches at most one RAM slot; the second word from each end is
// fetched through the RAM's registered read port and resolved on the next op.
// Reset empties the deque at once; slot contents are never cleared.
// A stalled result holds the result register, and the input register fills
// behind it before in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import dq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire dq_in_t  in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output dq_out_t      out_data_o
);

  logic    s1_valid_q, s1_valid_d;
  dq_in_t  s1_op_q;
  logic    out_valid_q, out_valid_d;
  dq_out_t out_data_q;
  dq_out_t res;
  logic    advance, in_accept;

  // operation datapath
  dq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .op_i   (s1_op_q),
    .res_o  (res)
  );

  // flow control
  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

endmodule

`default_nettype wire
